[sv/reflected_crc32_stream_defines.svh]
// Assertion macros for the reflected CRC-32 stream block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef REFLECTED_CRC32_STREAM_DEFINES_SVH
`define REFLECTED_CRC32_STREAM_DEFINES_SVH

`ifndef SYNTH
// Checked on every clock edge once reset is released.
`define RCRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Checked on every clock edge, during reset too.
`define RCRC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");
`else
`define RCRC_ASSERT(lbl, prop)
`define RCRC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[sv/rcrc32_pkg.sv]
// Package for the reflected CRC-32 stream block: payload types, register
// indexes, constants and the byte fold and byte reversal functions. No dependencies.
package rcrc32_pkg;

  localparam int unsigned CrcW   = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CrcW-1:0] AllOnes   = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] StockPoly = 32'hEDB8_8320;

  localparam logic [CfgIdxW-1:0] CfgPolynomial = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgSwapResult = 1'd1;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } in_item_t;

  typedef struct packed {
    logic [CrcW-1:0] crc_value;
  } out_item_t;

  // Eight reflected shift-and-xor steps, unrolled.
  function automatic logic [CrcW-1:0] fold_byte(logic [CrcW-1:0] rem,
                                                logic [ByteW-1:0] data,
                                                logic [CrcW-1:0] poly);
    logic [CrcW-1:0] r;
    r = rem ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int k = 0; k < ByteW; k++) begin
      r = (r >> 1) ^ (r[0] ? poly : '0);
    end
    return r;
  endfunction

  function automatic logic [CrcW-1:0] reverse_bytes(logic [CrcW-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

[sv/rcrc32_if.sv]
// Stream interfaces for the reflected CRC-32 block: message bytes in, CRC words out.
// Depends on rcrc32_pkg for the payload types.
interface rcrc32_in_if;
  logic                 valid;
  logic                 ready;
  rcrc32_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rcrc32_out_if;
  logic                  valid;
  logic                  ready;
  rcrc32_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/reflected_crc32_stream.sv]
// Top level of the reflected CRC-32 stream block.
// Depends on rcrc32_pkg, the interfaces in rcrc32_if.sv and the assertion macros header.
//
// The block takes one message byte per cycle and emits one CRC word per message, on
// the byte marked last: the running remainder (reset to all ones) is xored with all
// ones and, when swap_result is set, byte-reversed, then the remainder reloads all
// ones. A byte is held in the input register while one unrolled eight-step xor
// network folds it into the remainder; when a last byte moves on, the finished CRC
// is loaded into the output register, where it is held valid until it is taken.
// The input stalls only when a last byte is waiting behind an output word not yet taken.
// Register 0 is the reflected polynomial (reset 0xEDB88320), register 1 swap_result.
`include "reflected_crc32_stream_defines.svh"

module reflected_crc32_stream (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rcrc32_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rcrc32_pkg::CrcW-1:0]       cfg_data_i,
  rcrc32_in_if.sink                         in_if,
  rcrc32_out_if.source                      out_if
);

  logic [rcrc32_pkg::CrcW-1:0]  poly_q;
  logic                         swap_q;
  logic [rcrc32_pkg::CrcW-1:0]  rem_q, rem_d;
  logic                         s1_valid_q;
  logic [rcrc32_pkg::ByteW-1:0] s1_byte_q;
  logic                         s1_last_q;
  logic                         out_valid_q;
  logic [rcrc32_pkg::CrcW-1:0]  out_crc_q, out_crc_d;
  logic                         out_free;
  logic                         adv;
  logic [rcrc32_pkg::CrcW-1:0]  folded;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= rcrc32_pkg::StockPoly;
      swap_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcrc32_pkg::CfgPolynomial: poly_q <= cfg_data_i;
        rcrc32_pkg::CfgSwapResult: swap_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The held byte moves on unless it closes a message and the output is still full.
  assign out_free     = !out_valid_q || out_if.ready;
  assign adv          = s1_valid_q && (!s1_last_q || out_free);
  assign in_if.ready  = !s1_valid_q || adv;

  assign folded    = rcrc32_pkg::fold_byte(rem_q, s1_byte_q, poly_q);
  assign rem_d     = s1_last_q ? rcrc32_pkg::AllOnes : folded;
  assign out_crc_d = swap_q ? rcrc32_pkg::reverse_bytes(~folded) : ~folded;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      s1_byte_q <= in_if.payload.data_byte;
      s1_last_q <= in_if.payload.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= rcrc32_pkg::AllOnes;
    end else if (adv) begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_last_q) begin
      out_crc_q <= out_crc_d;
    end
  end

  assign out_if.valid             = out_valid_q;
  assign out_if.payload.crc_value = out_crc_q;

  `RCRC_ASSERT(a_last_loads_output, (adv && s1_last_q) |=> out_valid_q)
  `RCRC_ASSERT(a_last_reloads_rem, (adv && s1_last_q) |=> (rem_q == rcrc32_pkg::AllOnes))
  `RCRC_ASSERT(a_stall_cause, !in_if.ready |-> (s1_valid_q && s1_last_q && out_valid_q && !out_if.ready))
  `RCRC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (!out_valid_q && !s1_valid_q))

endmodule
